>>> hw/rtl/hce_pkg.sv
// ----------------------------------------------------------------------------
// hce_pkg: shared types and constants for the Huffman code encoder
// Operation codes, field widths, queue sizing and the queue item struct.
// ----------------------------------------------------------------------------
package hce_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int BYTE_BITS    = 8;
    localparam int WORD_BITS    = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;

    localparam int SYM_W   = 8;
    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int ENTRY_W = LEN_W + CODE_W;
    localparam int ACC_W   = WORD_BITS + BYTE_BITS;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // code_left: code word left aligned in the word, bits below length zero
    typedef struct packed {
        op_t                op;
        logic [CODE_W-1:0]  code_left;
        logic [LEN_W-1:0]   len;
    } item_t;

endpackage

>>> hw/rtl/hce_ram.sv
// ----------------------------------------------------------------------------
// hce_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hce_front.sv
// ----------------------------------------------------------------------------
// hce_front: input side of the encoder
// Accepts transactions, writes table entries, looks up codes and pushes
// encode and flush work into the queue.
// ----------------------------------------------------------------------------
module hce_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hce_pkg::S_TDATA_W-1:0] s_tdata,  // symbol, code_bits, code_length
    input  logic [hce_pkg::S_TUSER_W-1:0] s_tuser,  // operation
    input  logic [hce_pkg::QCNT_W-1:0]    q_count,
    output logic                          q_push,
    output hce_pkg::item_t                q_item
);
    import hce_pkg::*;

    logic                    accept;
    op_t                     in_op;
    logic [SYM_W-1:0]        in_sym;
    logic [CODE_W-1:0]       in_code;
    logic [LEN_W-1:0]        in_len;
    logic [LEN_W-1:0]        len_sat;
    logic                    sym_ok;
    logic                    tbl_we;
    logic [ENTRY_W-1:0]      tbl_rdata;
    logic [QCNT_W:0]         occupancy;

    logic [SYMBOL_COUNT-1:0] vld_reg, vld_next;
    logic                    s1_valid_reg;
    op_t                     s1_op_reg;
    logic                    s1_hit_reg;

    logic [LEN_W-1:0]        rd_len;
    logic [CODE_W-1:0]       rd_code;

    assign in_op   = op_t'(s_tuser);
    assign in_sym  = s_tdata[SYM_W-1:0];
    assign in_code = s_tdata[SYM_W +: CODE_W];
    assign in_len  = s_tdata[SYM_W + CODE_W +: LEN_W];

    // a stage 1 item may land in the queue, so reserve room for it
    assign occupancy = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg);
    assign s_tready  = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept    = s_tvalid && s_tready;

    assign sym_ok  = {1'b0, in_sym} < (SYM_W+1)'(SYMBOL_COUNT);
    assign len_sat = (in_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : in_len;
    assign tbl_we  = accept && (in_op == OP_LOAD) && sym_ok;

    hce_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (in_sym[ADDR_W-1:0]),
        .wdata ({len_sat, in_code}),
        .re    (accept),
        .raddr (in_sym[ADDR_W-1:0]),
        .rdata (tbl_rdata)
    );

    always_comb begin
        vld_next = vld_reg;
        if (tbl_we) begin
            vld_next[in_sym[ADDR_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            vld_reg      <= vld_next;
            s1_valid_reg <= accept;
        end
        if (accept) begin
            s1_op_reg  <= in_op;
            s1_hit_reg <= sym_ok && vld_reg[in_sym[ADDR_W-1:0]];
        end
    end

    // an entry never loaded reads as length zero
    assign rd_len  = s1_hit_reg ? tbl_rdata[CODE_W +: LEN_W] : '0;
    assign rd_code = tbl_rdata[CODE_W-1:0];

    always_comb begin
        q_item.op        = s1_op_reg;
        q_item.len       = rd_len;
        q_item.code_left = rd_code << (LEN_W'(WORD_BITS) - rd_len);
        q_push           = s1_valid_reg &&
                           ((s1_op_reg == OP_FLUSH) ||
                            ((s1_op_reg == OP_ENCODE) && (rd_len != '0)));
    end

endmodule

>>> hw/rtl/hce_queue.sv
// ----------------------------------------------------------------------------
// hce_queue: work queue between front and back
// Small register FIFO of queue items with an occupancy count.
// ----------------------------------------------------------------------------
module hce_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  hce_pkg::item_t             push_item,
    input  logic                       pop,
    output logic                       head_valid,
    output hce_pkg::item_t             head_item,
    output logic [hce_pkg::QCNT_W-1:0] count
);
    import hce_pkg::*;

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = cnt_reg != '0;
    assign head_item  = slot_reg[rd_ptr_reg];
    assign count      = cnt_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

>>> hw/rtl/hce_back.sv
// ----------------------------------------------------------------------------
// hce_back: bit packer and output register
// Appends queued codes to a left-aligned bit accumulator and, while the output
// is free, emits one byte per cycle; a flush pads pending bits into the last byte.
// ----------------------------------------------------------------------------
module hce_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  hce_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hce_pkg::M_TDATA_W-1:0] m_tdata,  // out_byte
    output logic                          m_tlast   // last
);
    import hce_pkg::*;

    // accumulator: valid bits sit at the top, everything below them is zero
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 mvalid_reg;
    logic [M_TDATA_W-1:0] mdata_reg;
    logic                 mlast_reg;

    logic                 out_free;
    logic                 emit;
    logic                 flush_out;
    logic [ACC_W-1:0]     base_acc;
    logic [CNT_W-1:0]     base_cnt;

    assign out_free = !mvalid_reg || m_tready;

    always_comb begin
        emit      = out_free && (cnt_reg >= CNT_W'(BYTE_BITS));
        base_acc  = emit ? {acc_reg[ACC_W-BYTE_BITS-1:0], {BYTE_BITS{1'b0}}} : acc_reg;
        base_cnt  = emit ? cnt_reg - CNT_W'(BYTE_BITS) : cnt_reg;
        q_pop     = 1'b0;
        flush_out = 1'b0;
        acc_next  = base_acc;
        cnt_next  = base_cnt;
        // next item may enter in the same cycle as the last full byte leaves
        if (q_valid && (base_cnt < CNT_W'(BYTE_BITS))) begin
            case (q_item.op)
                OP_ENCODE: begin
                    q_pop    = 1'b1;
                    acc_next = base_acc |
                               ({q_item.code_left, {BYTE_BITS{1'b0}}} >> base_cnt[2:0]);
                    cnt_next = base_cnt + CNT_W'(q_item.len);
                end
                OP_FLUSH: begin
                    if (base_cnt == '0) begin
                        q_pop = 1'b1;
                    end else if (!emit && out_free) begin
                        q_pop     = 1'b1;
                        flush_out = 1'b1;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                end
                default: begin
                    q_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            if (emit || flush_out) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
        if (emit || flush_out) begin
            mdata_reg <= acc_reg[ACC_W-1 -: BYTE_BITS];
            mlast_reg <= flush_out;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(ACC_W))
        else $error("bit count out of range");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg < CNT_W'(BYTE_BITS)) |-> (acc_reg[ACC_W-BYTE_BITS-1:0] == '0))
        else $error("bits below pending byte not clear");

    a_flush_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(emit && flush_out))
        else $error("flush byte and data byte in one cycle");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_out |=> (cnt_reg == '0) && mvalid_reg && mlast_reg)
        else $error("flush did not clear accumulator");

endmodule

>>> hw/rtl/huffman_code_encoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_encoder_unit: Huffman encoder with loadable code table
// Front stage accepts load/encode/flush transactions, a 4-entry queue feeds
// the bit packer that emits the packed byte stream.
// ----------------------------------------------------------------------------
// Usage: every input transaction is accepted while the queue has room. A load
// writes one 256-entry table entry (length saturated to 32) and produces
// nothing; the table is valid right after reset, with all lengths zero, and
// needs no clearing pass. An encode transaction passes the table read stage
// and the queue before it reaches the packer; the packer then sends one byte
// per cycle while the output register is free, and the next item enters in
// the same cycle as the last full byte leaves. A flush with pending bits sends
// one zero-padded byte with m_tlast set; a flush with nothing pending sends
// nothing. The single-byte output register and the queue let input and output
// stall independently.
module huffman_code_encoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hce_pkg::S_TDATA_W-1:0] s_tdata,  // symbol[7:0], code_bits[39:8],
                                                    // code_length[45:40], zero pad
    input  logic [hce_pkg::S_TUSER_W-1:0] s_tuser,  // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [hce_pkg::M_TDATA_W-1:0] m_tdata,  // out_byte
    output logic                          m_tlast   // last
);
    import hce_pkg::*;

    logic               q_push;
    item_t              q_push_item;
    logic               q_pop;
    logic               q_head_valid;
    item_t              q_head_item;
    logic [QCNT_W-1:0]  q_count;

    hce_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_item   (q_push_item)
    );

    hce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_push_item),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item),
        .count      (q_count)
    );

    hce_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_head_valid),
        .q_item   (q_head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
